// ----- sv/pmw_pkg.sv -----
// shared types and constants for the prim minimum spanning tree block
package pmw_pkg;

    // fixed widths of the transaction fields
    localparam int IN_WEIGHT_W = 17;
    localparam int IN_MAG_W    = 16;
    localparam int VALUE_W     = 21;
    localparam int CFG_W       = 6;

    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    // result kinds
    localparam logic KIND_EDGE  = 1'b0;
    localparam logic KIND_TOTAL = 1'b1;

    // input transaction
    typedef struct packed {
        logic signed [IN_WEIGHT_W-1:0] edge_weight;
        logic                          last_entry;
    } t_in_item;

    // output transaction
    typedef struct packed {
        logic               result_kind;
        logic [VALUE_W-1:0] value;
        logic               last_result;
    } t_out_item;

    // sequencer controls for the relax and select datapath
    typedef struct packed {
        logic issue;       // read one vertex this cycle
        logic init;        // seeding pass: cost comes from row 0 only
        logic clear_best;  // restart the minimum search
        logic seed_mask;   // tree holds vertex 0 only
        logic mark;        // add the selected vertex to the tree
    } t_relax_ctl;

endpackage

// ----- sv/pmw_matrix.sv -----
// weight matrix memory with the row-major load counter and weight encoding
module pmw_matrix #(
    parameter int MAX_NODES   = 32,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_load,
    input  pmw_pkg::t_in_item                                i_item,
    input  logic [$clog2(MAX_NODES*MAX_NODES+1)-1:0]         i_cell_limit,
    input  logic [$clog2(MAX_NODES*MAX_NODES)-1:0]           i_rd_addr,
    output logic [((WEIGHT_BITS < 16) ? WEIGHT_BITS : 16):0] o_rd_data
);
    import pmw_pkg::*;

    localparam int CELLS  = MAX_NODES * MAX_NODES;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int POS_W  = $clog2(CELLS + 1);
    localparam int SW     = (WEIGHT_BITS < IN_MAG_W) ? WEIGHT_BITS : IN_MAG_W;
    localparam int EW     = SW + 1;

    logic [EW-1:0]    r_mem [CELLS];
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [EW-1:0]    enc;
    logic [SW-1:0]    mag;
    logic             wr_en;

    // negative means no edge (flag set, weight zero); large weights saturate
    always_comb begin
        if (IN_MAG_W'(i_item.edge_weight[IN_MAG_W-1:0]) > IN_MAG_W'({SW{1'b1}})) begin
            mag = {SW{1'b1}};
        end else begin
            mag = SW'(i_item.edge_weight[IN_MAG_W-1:0]);
        end
        if (i_item.edge_weight[IN_WEIGHT_W-1]) begin
            enc = {1'b1, {SW{1'b0}}};
        end else begin
            enc = {1'b0, mag};
        end
    end

    // entries beyond n*n are dropped
    assign wr_en = i_load && (r_pos < i_cell_limit);

    always_comb begin
        n_pos = r_pos;
        if (i_load) begin
            if (i_item.last_entry) begin
                n_pos = '0;
            end else if (wr_en) begin
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_pos[ADDR_W-1:0]] <= enc;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// ----- sv/pmw_relax.sv -----
// min-cost memory, tree mask and the relax plus minimum-select stage
module pmw_relax #(
    parameter int MAX_NODES   = 32,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  pmw_pkg::t_relax_ctl                              i_ctl,
    input  logic [$clog2(MAX_NODES)-1:0]                     i_v,
    input  logic [((WEIGHT_BITS < 16) ? WEIGHT_BITS : 16):0] i_mat_data,
    output logic [((WEIGHT_BITS < 16) ? WEIGHT_BITS : 16):0] o_best,
    output logic [$clog2(MAX_NODES)-1:0]                     o_pick
);
    import pmw_pkg::*;

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int SW    = (WEIGHT_BITS < IN_MAG_W) ? WEIGHT_BITS : IN_MAG_W;
    localparam int EW    = SW + 1;
    localparam logic [EW-1:0] INF = {1'b1, {SW{1'b0}}};

    logic [EW-1:0]        r_cost_mem [MAX_NODES];
    logic [EW-1:0]        r_cost;
    logic [IDX_W-1:0]     r_v_d;
    logic                 r_vld_d;
    logic                 r_init_d;
    logic [MAX_NODES-1:0] r_mask;
    logic [EW-1:0]        r_best;
    logic [IDX_W-1:0]     r_pick;

    logic [EW-1:0] cur;
    logic [EW-1:0] upd;
    logic          seen;
    logic          take;

    // read stage: cost entry and the matrix entry arrive together next cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.issue) begin
            r_cost <= r_cost_mem[i_v];
        end
        r_v_d    <= i_v;
        r_init_d <= i_ctl.init;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_d <= 1'b0;
        end else begin
            r_vld_d <= i_ctl.issue;
        end
    end

    // relax against the new tree vertex row, then feed the minimum search
    always_comb begin
        seen = r_mask[r_v_d];
        cur  = r_init_d ? INF : r_cost;
        upd  = (!seen && (cur > i_mat_data)) ? i_mat_data : cur;
        take = r_vld_d && !seen && (upd < r_best);
    end

    // write-back goes to the entry read in the previous cycle, never the one being read
    always_ff @(posedge i_clk) begin
        if (r_vld_d) begin
            r_cost_mem[r_v_d] <= upd;
        end
    end

    // running minimum, lowest vertex wins on ties
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= INF;
            r_pick <= '0;
        end else if (i_ctl.clear_best) begin
            r_best <= INF;
            r_pick <= '0;
        end else if (take) begin
            r_best <= upd;
            r_pick <= r_v_d;
        end
    end

    // tree membership
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_ctl.seed_mask) begin
            r_mask <= MAX_NODES'(1);
        end else if (i_ctl.mark) begin
            r_mask[r_pick] <= 1'b1;
        end
    end

    assign o_best = r_best;
    assign o_pick = r_pick;

endmodule

// ----- sv/prim_mst_weights.sv -----
// top level: configuration, run sequencer, total accumulation and result register
//
// Matrix entries are loaded one per cycle while busy is low, row-major for the
// configured vertex count n; entries past n*n are ignored. The transaction with
// last_entry raises busy and starts the tree build from vertex 0. Each pass reads
// the min-cost memory and the weight matrix one vertex per cycle, then drains the
// read stage and decides; a run has at most n passes. Every edge that joins the
// tree comes out on o_valid for one cycle, followed by the total flagged as last,
// which appears in the first cycle with busy low. Results cannot be held off: the
// receiver must take o_result whenever o_valid is high. The vertex count is written
// through i_cfg_we/i_cfg_wdata; the user must write it only while busy is low, as
// the block does not enforce it; 0 acts as 1 and values above MAX_NODES saturate.
module prim_mst_weights #(
    parameter int MAX_NODES   = 32,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  pmw_pkg::t_in_item        i_item,
    input  logic                     i_cfg_we,
    input  logic [pmw_pkg::CFG_W-1:0] i_cfg_wdata,
    output logic                     o_valid,
    output pmw_pkg::t_out_item       o_result
);
    import pmw_pkg::*;

    localparam int NODE_W      = $clog2(MAX_NODES + 1);
    localparam int IDX_W       = $clog2(MAX_NODES);
    localparam int CELLS       = MAX_NODES * MAX_NODES;
    localparam int ADDR_W      = $clog2(CELLS);
    localparam int POS_W       = $clog2(CELLS + 1);
    localparam int SW          = (WEIGHT_BITS < IN_MAG_W) ? WEIGHT_BITS : IN_MAG_W;
    localparam int EW          = SW + 1;
    localparam int RESET_NODES = (MAX_NODES < 32) ? MAX_NODES : 32;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SWEEP  = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_DECIDE = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_v, n_v;
    logic             r_first, n_first;
    logic [ADDR_W-1:0] r_base, n_base;
    logic [VALUE_W-1:0] r_total, n_total;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;
    logic [NODE_W-1:0] r_node_count;
    logic [POS_W-1:0] r_cell_limit;

    logic [NODE_W-1:0] cfg_nodes;
    logic              accept;
    logic              last_v;
    logic              best_inf;
    logic [VALUE_W:0]  sum;
    t_relax_ctl        ctl;
    logic [EW-1:0]     mat_data;
    logic [EW-1:0]     best;
    logic [IDX_W-1:0]  pick;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // vertex count clamp and cell limit
    always_comb begin
        if (32'(i_cfg_wdata) > MAX_NODES) begin
            cfg_nodes = NODE_W'(MAX_NODES);
        end else if (i_cfg_wdata == '0) begin
            cfg_nodes = NODE_W'(1);
        end else begin
            cfg_nodes = NODE_W'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_W'(RESET_NODES);
            r_cell_limit <= POS_W'(RESET_NODES * RESET_NODES);
        end else if (i_cfg_we) begin
            r_node_count <= cfg_nodes;
            r_cell_limit <= POS_W'(POS_W'(cfg_nodes) * POS_W'(cfg_nodes));
        end
    end

    // matrix store and load counter
    pmw_matrix #(
        .MAX_NODES   (MAX_NODES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_matrix (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (accept),
        .i_item       (i_item),
        .i_cell_limit (r_cell_limit),
        .i_rd_addr    (r_base + ADDR_W'(r_v)),
        .o_rd_data    (mat_data)
    );

    // min-cost memory and selection
    pmw_relax #(
        .MAX_NODES   (MAX_NODES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_relax (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_v        (r_v),
        .i_mat_data (mat_data),
        .o_best     (best),
        .o_pick     (pick)
    );

    assign last_v   = (NODE_W'(r_v) == (r_node_count - NODE_W'(1)));
    assign best_inf = best[EW-1];
    assign sum      = {1'b0, r_total} + (VALUE_W + 1)'(best[SW-1:0]);

    // run sequencer: sweep all vertices, drain the read stage, then decide
    always_comb begin
        n_state     = r_state;
        n_v         = r_v;
        n_first     = r_first;
        n_base      = r_base;
        n_total     = r_total;
        n_out_valid = 1'b0;
        n_out       = r_out;
        ctl         = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_item.last_entry) begin
                    n_state       = S_SWEEP;
                    n_v           = '0;
                    n_first       = 1'b1;
                    n_base        = '0;
                    n_total       = '0;
                    ctl.clear_best = 1'b1;
                    ctl.seed_mask  = 1'b1;
                end
            end
            S_SWEEP: begin
                ctl.issue = 1'b1;
                ctl.init  = r_first;
                if (last_v) begin
                    n_state = S_DRAIN;
                end else begin
                    n_v = r_v + IDX_W'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_out_valid = 1'b1;
                if (best_inf) begin
                    n_out.result_kind = KIND_TOTAL;
                    n_out.value       = r_total;
                    n_out.last_result = 1'b1;
                    n_state           = S_IDLE;
                end else begin
                    n_out.result_kind = KIND_EDGE;
                    n_out.value       = VALUE_W'(best[SW-1:0]);
                    n_out.last_result = 1'b0;
                    n_total           = sum[VALUE_W] ? VALUE_MAX : sum[VALUE_W-1:0];
                    ctl.mark          = 1'b1;
                    ctl.clear_best    = 1'b1;
                    n_first           = 1'b0;
                    n_base            = ADDR_W'(ADDR_W'(pick) * ADDR_W'(r_node_count));
                    n_v               = '0;
                    n_state           = S_SWEEP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_v         <= '0;
            r_first     <= 1'b0;
            r_base      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_v         <= n_v;
            r_first     <= n_first;
            r_base      <= n_base;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ----- sv/pmw_checker.sv -----
// port-level assertions for the prim minimum spanning tree block and its bind
module pmw_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input pmw_pkg::t_in_item   i_item,
    input logic                o_valid,
    input pmw_pkg::t_out_item  o_result
);
    import pmw_pkg::*;

    // the total closes the run, so the block is free again
    a_total_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.last_result |-> !busy)
        else $error("total shown while still busy");

    // an edge result is always followed by more work
    a_edge_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.last_result |-> busy)
        else $error("edge result shown while idle");

    // only the total is of the total kind
    a_kind_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.result_kind == o_result.last_result))
        else $error("result kind and last flag disagree");

    // the final matrix entry starts a run
    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_item.last_entry |=> busy)
        else $error("last entry did not start a run");

    // nothing follows the total of a run directly
    a_total_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.last_result |=> !o_valid)
        else $error("result right after the total");

endmodule

bind prim_mst_weights pmw_checker u_pmw_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_valid  (o_valid),
    .o_result (o_result)
);
